FILE: design/amas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amas_pkg
// Shared widths, defaults and the beat type for the moving-average slew core.
// ----------------------------------------------------------------------------
package amas_pkg;

  localparam int CHAN_W              = 2;
  localparam int RAW_W               = 12;
  localparam int SAMPLE_W            = 8;
  localparam int SAMPLE_LSB          = 4;
  localparam int SAMPLE_MAX          = 255;
  localparam int WINDOW_LENGTH_DEF   = 249;
  localparam int CHANNEL_COUNT_DEF   = 4;

  // average handed from the divide stage to the slew stage
  typedef struct packed {
    logic [CHAN_W-1:0]   channel;
    logic                used;
    logic [SAMPLE_W-1:0] average;
  } avg_beat_t;

endpackage
`default_nettype wire

FILE: design/amas_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amas_in_if
// Sample channel: channel number and raw converter reading.
// ----------------------------------------------------------------------------
interface amas_in_if;
  logic                         valid;
  logic                         ready;
  logic [amas_pkg::CHAN_W-1:0]  channel;
  logic [amas_pkg::RAW_W-1:0]   raw_sample;

  modport source (output valid, output channel, output raw_sample, input ready);
  modport sink   (input valid, input channel, input raw_sample, output ready);
endinterface
`default_nettype wire

FILE: design/amas_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amas_out_if
// Result channel: channel, window average and slew-limited value.
// ----------------------------------------------------------------------------
interface amas_out_if;
  logic                          valid;
  logic                          ready;
  logic [amas_pkg::CHAN_W-1:0]   channel_out;
  logic [amas_pkg::SAMPLE_W-1:0] window_average;
  logic [amas_pkg::SAMPLE_W-1:0] tracked_value;

  modport source (output valid, output channel_out, output window_average,
                  output tracked_value, input ready);
  modport sink   (input valid, input channel_out, input window_average,
                  input tracked_value, output ready);
endinterface
`default_nettype wire

FILE: design/amas_window_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amas_window_ram
// Sample window store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module amas_window_ram #(
  parameter int DEPTH  = 996,
  parameter int DATA_W = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data_r
);

  logic [DATA_W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: design/amas_slew_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amas_slew_unit
// Per-channel slew limiter state and the result output register.
// ----------------------------------------------------------------------------
module amas_slew_unit #(
  parameter int CHANNEL_COUNT = amas_pkg::CHANNEL_COUNT_DEF,
  parameter int CH_IDX_W      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                beat_valid,
  output logic                beat_ready,
  input  amas_pkg::avg_beat_t beat,
  amas_out_if.source          out_beat
);

  logic [amas_pkg::SAMPLE_W-1:0] slew_r [CHANNEL_COUNT];
  logic                          out_valid_r;
  logic [amas_pkg::CHAN_W-1:0]   out_ch_r;
  logic [amas_pkg::SAMPLE_W-1:0] out_avg_r;
  logic [amas_pkg::SAMPLE_W-1:0] out_trk_r;

  logic                          fire;
  logic [CH_IDX_W-1:0]           idx;
  logic [amas_pkg::SAMPLE_W-1:0] trk_cur;
  logic [amas_pkg::SAMPLE_W-1:0] trk_nxt;

  assign beat_ready = !out_valid_r || out_beat.ready;
  assign fire       = beat_valid && beat_ready;
  assign idx        = beat.used ? CH_IDX_W'(beat.channel) : '0;
  assign trk_cur    = slew_r[idx];

  always_comb begin
    priority if (trk_cur < beat.average) begin
      trk_nxt = trk_cur + 1'b1;
    end else if (trk_cur > beat.average) begin
      trk_nxt = trk_cur - 1'b1;
    end else begin
      trk_nxt = trk_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        slew_r[i] <= '0;
      end
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_beat.ready) begin
        out_valid_r <= 1'b0;
      end
      if (fire && beat.used) begin
        slew_r[idx] <= trk_nxt;
      end
    end
  end

  // unused channel reports zero average and tracked value
  always_ff @(posedge clk) begin
    if (fire) begin
      out_ch_r  <= beat.channel;
      out_avg_r <= beat.used ? beat.average : '0;
      out_trk_r <= beat.used ? trk_nxt : '0;
    end
  end

  assign out_beat.valid          = out_valid_r;
  assign out_beat.channel_out    = out_ch_r;
  assign out_beat.window_average = out_avg_r;
  assign out_beat.tracked_value  = out_trk_r;

endmodule
`default_nettype wire

FILE: design/adc_moving_average_slew_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adc_moving_average_slew_core
// Boxcar moving average of the top 8 sample bits, one window per channel,
// followed by a one-step-per-beat slew limiter.
// ----------------------------------------------------------------------------
// Takes one sample beat per cycle unless the result side stalls, and returns one
// result beat per sample through the RAM read, sum, product and output registers.
// After reset the core clears its window RAM, one entry per cycle, across all
// CHANNEL_COUNT * WINDOW_LENGTH entries (996 by default) with in_beat.ready low.
// Throughput is set by the single window RAM: each sample reads the oldest entry
// of its channel when accepted and writes the new one back as it leaves stage 1,
// while running sums, write positions and slew values sit in per-channel registers.
// Division by the window length is a constant-reciprocal multiply in its own stage.
// ----------------------------------------------------------------------------
module adc_moving_average_slew_core #(
  parameter int WINDOW_LENGTH = amas_pkg::WINDOW_LENGTH_DEF,
  parameter int CHANNEL_COUNT = amas_pkg::CHANNEL_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  amas_in_if.sink    in_beat,
  amas_out_if.source out_beat
);

  localparam int DEPTH     = WINDOW_LENGTH * CHANNEL_COUNT;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int POS_W     = $clog2(WINDOW_LENGTH);
  localparam int CH_IDX_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int SUM_MAX   = WINDOW_LENGTH * amas_pkg::SAMPLE_MAX;
  localparam int SUM_W     = $clog2(SUM_MAX + 1);
  // exact floor division for every SUM_W-bit value
  localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW_LENGTH);
  localparam longint RECIP = ((64'd1 << DIV_SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
  localparam int RECIP_W   = SUM_W + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);
  localparam logic [ADDR_W-1:0]  WIN_K   = ADDR_W'(WINDOW_LENGTH);
  localparam logic [POS_W-1:0]   POS_LAST = POS_W'(WINDOW_LENGTH - 1);
  localparam logic [ADDR_W-1:0]  ADDR_LAST = ADDR_W'(DEPTH - 1);

  // clearing sweep
  logic              clr_active_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // per-channel state
  logic [POS_W-1:0]  pos_r [CHANNEL_COUNT];
  logic [SUM_W-1:0]  sum_r [CHANNEL_COUNT];

  // stage 1: RAM read data returns
  logic                          s1_valid_r;
  logic [amas_pkg::CHAN_W-1:0]   s1_ch_r;
  logic                          s1_used_r;
  logic [CH_IDX_W-1:0]           s1_idx_r;
  logic [amas_pkg::SAMPLE_W-1:0] s1_sample_r;
  logic [ADDR_W-1:0]             s1_addr_r;

  // stage 2: updated window sum
  logic                          s2_valid_r;
  logic [amas_pkg::CHAN_W-1:0]   s2_ch_r;
  logic                          s2_used_r;
  logic [SUM_W-1:0]              s2_sum_r;

  // stage 3: reciprocal product
  logic                          s3_valid_r;
  logic [amas_pkg::CHAN_W-1:0]   s3_ch_r;
  logic                          s3_used_r;
  logic [PROD_W-1:0]             s3_prod_r;

  logic                          in_fire;
  logic                          in_used;
  logic [CH_IDX_W-1:0]           in_idx;
  logic [POS_W-1:0]              pos_cur;
  logic [POS_W-1:0]              pos_nxt;
  logic [amas_pkg::SAMPLE_W-1:0] in_sample;

  logic                          s1_ready;
  logic                          s2_ready;
  logic                          s3_ready;
  logic                          s1_fire;
  logic                          s2_fire;
  logic                          slew_ready;
  logic [SUM_W-1:0]              sum_nxt;

  logic                          ram_wr_en;
  logic [ADDR_W-1:0]             ram_wr_addr;
  logic [amas_pkg::SAMPLE_W-1:0] ram_wr_data;
  logic                          ram_rd_en;
  logic [ADDR_W-1:0]             ram_rd_addr;
  logic [amas_pkg::SAMPLE_W-1:0] ram_rd_data;

  amas_pkg::avg_beat_t           avg_beat;

  // ---------------------------------------------------------------- handshake
  assign s3_ready      = !s3_valid_r || slew_ready;
  assign s2_ready      = !s2_valid_r || s3_ready;
  assign s1_ready      = !s1_valid_r || s2_ready;
  assign s1_fire       = s1_valid_r && s2_ready;
  assign s2_fire       = s2_valid_r && s3_ready;
  assign in_beat.ready = !clr_active_r && s1_ready;
  assign in_fire       = in_beat.valid && in_beat.ready;

  // ---------------------------------------------------------------- accept
  assign in_used   = int'(in_beat.channel) < CHANNEL_COUNT;
  assign in_idx    = in_used ? CH_IDX_W'(in_beat.channel) : '0;
  assign in_sample = in_beat.raw_sample[amas_pkg::SAMPLE_LSB +: amas_pkg::SAMPLE_W];
  assign pos_cur   = pos_r[in_idx];
  assign pos_nxt   = (pos_cur == POS_LAST) ? '0 : pos_cur + 1'b1;

  assign ram_rd_en   = in_fire && in_used;
  assign ram_rd_addr = ADDR_W'(in_idx) * WIN_K + ADDR_W'(pos_cur);

  // ---------------------------------------------------------------- write back
  assign sum_nxt     = sum_r[s1_idx_r] + SUM_W'(s1_sample_r) - SUM_W'(ram_rd_data);
  assign ram_wr_en   = clr_active_r || (s1_fire && s1_used_r);
  assign ram_wr_addr = clr_active_r ? clr_addr_r : s1_addr_r;
  assign ram_wr_data = clr_active_r ? '0 : s1_sample_r;

  amas_window_ram #(
    .DEPTH  (DEPTH),
    .DATA_W (amas_pkg::SAMPLE_W),
    .ADDR_W (ADDR_W)
  ) u_window_ram (
    .clk       (clk),
    .wr_en     (ram_wr_en),
    .wr_addr   (ram_wr_addr),
    .wr_data   (ram_wr_data),
    .rd_en     (ram_rd_en),
    .rd_addr   (ram_rd_addr),
    .rd_data_r (ram_rd_data)
  );

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      s3_valid_r   <= 1'b0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        pos_r[i] <= '0;
        sum_r[i] <= '0;
      end
    end else begin
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_LAST) begin
          clr_active_r <= 1'b0;
        end
      end

      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_fire) begin
        s2_valid_r <= 1'b1;
      end else if (s2_fire) begin
        s2_valid_r <= 1'b0;
      end

      if (s2_fire) begin
        s3_valid_r <= 1'b1;
      end else if (slew_ready) begin
        s3_valid_r <= 1'b0;
      end

      if (in_fire && in_used) begin
        pos_r[in_idx] <= pos_nxt;
      end
      if (s1_fire && s1_used_r) begin
        sum_r[s1_idx_r] <= sum_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ch_r     <= in_beat.channel;
      s1_used_r   <= in_used;
      s1_idx_r    <= in_idx;
      s1_sample_r <= in_sample;
      s1_addr_r   <= ram_rd_addr;
    end
    if (s1_fire) begin
      s2_ch_r   <= s1_ch_r;
      s2_used_r <= s1_used_r;
      s2_sum_r  <= sum_nxt;
    end
    if (s2_fire) begin
      s3_ch_r   <= s2_ch_r;
      s3_used_r <= s2_used_r;
      s3_prod_r <= PROD_W'(s2_sum_r) * PROD_W'(RECIP_K);
    end
  end

  assign avg_beat.channel = s3_ch_r;
  assign avg_beat.used    = s3_used_r;
  assign avg_beat.average = s3_prod_r[DIV_SHIFT +: amas_pkg::SAMPLE_W];

  amas_slew_unit #(
    .CHANNEL_COUNT (CHANNEL_COUNT),
    .CH_IDX_W      (CH_IDX_W)
  ) u_slew_unit (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (s3_valid_r),
    .beat_ready (slew_ready),
    .beat       (avg_beat),
    .out_beat   (out_beat)
  );

`ifndef ASSERT_OFF
  // the window RAM never reads and writes the same entry together
  a_ram_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
    else $error("window RAM read and write hit the same entry");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !(s1_valid_r || s2_valid_r || s3_valid_r || out_beat.valid))
    else $error("pipeline holds a beat during the RAM clearing pass");

  // running sum must not exceed a full window of maximum samples (SUM_MAX)
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (s2_sum_r <= SUM_W'(SUM_MAX)))
    else $error("window sum out of range");
`endif

endmodule
`default_nettype wire

FILE: bench/tb_adc_moving_average_slew_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adc_moving_average_slew_core
// Self-checking bench for the four-channel boxcar average and slew limiter.
// A queued driver feeds sample beats in random bursts. A clocked predictor
// keeps its own windows, running sums and slew values and computes the result
// each accepted sample should produce. The monitor stalls on its own pattern,
// holds off once for a long stretch, and checks every result beat field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_adc_moving_average_slew_core;
  import amas_pkg::*;

  localparam int WIN_LEN    = WINDOW_LENGTH_DEF;
  localparam int CHAN_COUNT = CHANNEL_COUNT_DEF;
  localparam int DRAIN_CYC  = 40;

  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [RAW_W-1:0]  raw;
  } sample_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] average;
    logic [SAMPLE_W-1:0] tracked;
  } pot_result_t;

  logic clk = 1'b0;
  logic rst_n;

  amas_in_if  in_bus ();
  amas_out_if out_bus ();

  adc_moving_average_slew_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_beat  (in_bus),
    .out_beat (out_bus)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [SAMPLE_W-1:0] win_mem  [CHAN_COUNT][WIN_LEN];
  logic [15:0]         run_sum  [CHAN_COUNT];
  int unsigned         head_pos [CHAN_COUNT];
  logic [SAMPLE_W-1:0] slew_val [CHAN_COUNT];

  sample_t     pending_samples[$];
  pot_result_t expected_results[$];

  int unsigned gap_left   = 0;
  int unsigned burst_left = 1;
  sample_t     next_sample;

  int unsigned results_seen = 0;
  int unsigned errors       = 0;
  int unsigned hold_left    = 0;
  logic        hold_done    = 1'b0;
  int unsigned stall_mode   = 0;
  int unsigned mode_left    = 0;
  int unsigned mode_phase   = 0;
  logic        ready_pick;
  pot_result_t oldest;

  function automatic pot_result_t track_sample(logic [CHAN_W-1:0] chan,
                                               logic [RAW_W-1:0] raw);
    logic [SAMPLE_W-1:0] reduced;
    logic [15:0]         new_sum;
    logic [15:0]         quotient;
    int unsigned         pos;
    pot_result_t         r;
    reduced   = raw[RAW_W-1:SAMPLE_LSB];
    r.channel = chan;
    if (chan >= CHAN_COUNT) begin
      r.average = '0;
      r.tracked = '0;
      return r;
    end
    pos               = head_pos[chan];
    new_sum           = run_sum[chan] + reduced - win_mem[chan][pos];
    win_mem[chan][pos] = reduced;
    run_sum[chan]     = new_sum;
    head_pos[chan]    = (pos + 1 >= WIN_LEN) ? 0 : pos + 1;
    quotient          = 16'(new_sum / WIN_LEN);
    r.average         = quotient[SAMPLE_W-1:0];
    if (slew_val[chan] < r.average)
      slew_val[chan] = slew_val[chan] + 1'b1;
    else if (slew_val[chan] > r.average)
      slew_val[chan] = slew_val[chan] - 1'b1;
    r.tracked = slew_val[chan];
    return r;
  endfunction

  task automatic queue_sample(input int unsigned chan, input int unsigned raw);
    sample_t s;
    s.channel = CHAN_W'(chan);
    s.raw     = RAW_W'(raw);
    pending_samples.push_back(s);
  endtask

  task automatic report_mismatch(input string field, input int unsigned exp_v,
                                 input int unsigned got_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
    errors++;
  endtask

  // sender: bursts of random length, random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready)
        expected_results.push_back(track_sample(in_bus.channel, in_bus.raw_sample));
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left != 0 || pending_samples.size() == 0) begin
          in_bus.valid <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end else begin
          next_sample = pending_samples.pop_front();
          in_bus.valid      <= 1'b1;
          in_bus.channel    <= next_sample.channel;
          in_bus.raw_sample <= next_sample.raw;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // one long hold-off on the result side so the core backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= 150) begin
      hold_left <= 120;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver: checks result beats, stalls on a mode that changes now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, channel %0d avg %0d trk %0d",
                   $time, out_bus.channel_out, out_bus.window_average,
                   out_bus.tracked_value);
          errors++;
        end else begin
          oldest = expected_results.pop_front();
          if (out_bus.channel_out !== oldest.channel)
            report_mismatch("channel_out", oldest.channel, out_bus.channel_out);
          if (out_bus.window_average !== oldest.average)
            report_mismatch("window_average", oldest.average, out_bus.window_average);
          if (out_bus.tracked_value !== oldest.tracked)
            report_mismatch("tracked_value", oldest.tracked, out_bus.tracked_value);
        end
      end
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(16, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      mode_phase <= (mode_phase == 2) ? 0 : mode_phase + 1;
      case (stall_mode)
        0: ready_pick = 1'b1;
        1: ready_pick = ($urandom_range(0, 3) != 0);
        default: ready_pick = (mode_phase != 0);
      endcase
      out_bus.ready <= ready_pick && (hold_left == 0);
    end
  end

  initial begin : run_limit
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned focus;
    int unsigned level;
    int          jittered;
    int unsigned seg;
    int unsigned k;

    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.channel     = '0;
    in_bus.raw_sample  = '0;
    out_bus.ready      = 1'b0;
    for (int c = 0; c < CHAN_COUNT; c++) begin
      run_sum[c]  = '0;
      head_pos[c] = 0;
      slew_val[c] = '0;
      for (int i = 0; i < WIN_LEN; i++) win_mem[c][i] = '0;
    end

    // directed: full scale, zero, dropped low nibble, first kept bit
    for (int c = 0; c < CHAN_COUNT; c++) begin
      queue_sample(c, 12'hFFF);
      queue_sample(c, 12'h00F);
    end
    queue_sample(0, 12'h010);
    queue_sample(0, 12'h01F);
    queue_sample(1, 12'hFF0);
    queue_sample(1, 12'h000);
    queue_sample(2, 12'h800);
    queue_sample(2, 12'h7FF);
    queue_sample(3, 12'hA5A);
    queue_sample(3, 12'h5A5);
    queue_sample(0, 12'h000);

    // full-scale run past the window length, then back down to zero:
    // average reaches 255, position wraps, slew goes both ways
    focus = $urandom_range(0, 3);
    for (k = 0; k < 2 * (WIN_LEN + 11); k++) begin
      if ($urandom_range(0, 7) == 0)
        queue_sample((focus + $urandom_range(1, 3)) % 4, $urandom_range(0, 4095));
      if (k < WIN_LEN + 11)
        queue_sample(focus, $urandom_range(12'hFF0, 12'hFFF));
      else
        queue_sample(focus, $urandom_range(12'h000, 12'h00F));
    end

    // steady levels with jitter on a focus channel, mixed with noise
    for (seg = 0; seg < 4; seg++) begin
      focus = $urandom_range(0, 3);
      level = $urandom_range(0, 255);
      for (k = 0; k < $urandom_range(15, 40); k++) begin
        if ($urandom_range(0, 3) == 0) begin
          queue_sample($urandom_range(0, 3), $urandom_range(0, 4095));
        end else begin
          jittered = int'(level) + int'($urandom_range(0, 6)) - 3;
          if (jittered < 0)   jittered = 0;
          if (jittered > 255) jittered = 255;
          queue_sample(focus, (jittered << SAMPLE_LSB) | $urandom_range(0, 15));
        end
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_samples.size() != 0 || in_bus.valid || expected_results.size() != 0);
    repeat (DRAIN_CYC) @(posedge clk);
    @(negedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      errors++;
    end

    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
